@@ hdl/takf_pkg.sv @@
// ----------------------------------------------------------------------------
// takf_pkg: shared types and constants of the tilt angle Kalman filter
// Field widths, register indexes, arithmetic unit op codes and handshake
// structs used by the filter top level and its serial arithmetic unit.
// ----------------------------------------------------------------------------
package takf_pkg;

    // defaults for the top level parameters
    localparam int WORD_WIDTH_DEF = 48;
    localparam int FRAC_BITS_DEF  = 24;

    // payload and register widths
    localparam int ANGLE_W   = 33;
    localparam int RATE_W    = 36;
    localparam int QA_W      = 25;
    localparam int QB_W      = 25;
    localparam int RN_W      = 29;
    localparam int DT_W      = 25;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 29;

    // output saturation limits
    localparam longint ANGLE_LIMIT = 64'sd3019898880;
    localparam longint RATE_LIMIT  = 64'sd33554432000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_Q = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_Q  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_R  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 3'd3;

    // register reset values
    localparam logic [QA_W-1:0] QA_RST = 25'd16777;
    localparam logic [QB_W-1:0] QB_RST = 25'd50332;
    localparam logic [RN_W-1:0] RN_RST = 29'd8388608;
    localparam logic [DT_W-1:0] DT_RST = 25'd83886;

    // arithmetic unit operations
    localparam logic OP_MUL = 1'b0;
    localparam logic OP_DIV = 1'b1;

    typedef struct packed {
        logic go;
        logic op;
    } t_mdu_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mdu_sts;

endpackage

@@ hdl/takf_in_if.sv @@
// ----------------------------------------------------------------------------
// takf_in_if: sample channel
// Valid/ready channel carrying one accelerometer angle and gyro rate beat.
// ----------------------------------------------------------------------------
interface takf_in_if;
    logic               valid;
    logic               ready;
    logic signed [32:0] measured_angle;
    logic signed [35:0] gyro_rate;

    modport source (output valid, output measured_angle, output gyro_rate, input ready);
    modport sink   (input valid, input measured_angle, input gyro_rate, output ready);
endinterface

@@ hdl/takf_out_if.sv @@
// ----------------------------------------------------------------------------
// takf_out_if: result channel
// Valid/ready channel carrying one filtered angle and corrected rate beat.
// ----------------------------------------------------------------------------
interface takf_out_if;
    logic               valid;
    logic               ready;
    logic signed [32:0] filtered_angle;
    logic signed [35:0] corrected_rate;

    modport source (output valid, output filtered_angle, output corrected_rate, input ready);
    modport sink   (input valid, input filtered_angle, input corrected_rate, output ready);
endinterface

@@ hdl/tilt_angle_kalman_filter_top.sv @@
// ----------------------------------------------------------------------------
// tilt_angle_kalman_filter_top: two-state angle / gyro bias Kalman filter
// Fuses an accelerometer tilt angle with a gyro rate, fixed point throughout.
// ----------------------------------------------------------------------------
// Usage:
//   i_sample carries one beat per IMU sample: measured_angle and gyro_rate,
//   signed with FRAC_BITS fractional bits. o_result returns one beat per
//   sample: filtered_angle and the bias-corrected rate, both saturated.
//   Noise terms and the sample period are written on the i_cfg_* port; the
//   user must write them only while no sample is in flight, as the block
//   does not enforce it. Indexes beyond the four registers are dropped.
//   Scheduling: one sample is worked at a time. All products and quotients
//   go through one shared bit-serial multiply/divide unit, one bit per
//   cycle. The result beat turns valid sooner when the innovation variance
//   is not positive and the correction is skipped. The next sample can be
//   taken in the same cycle that the result beat turns valid. The unit's
//   bit loop sets the time that a sample takes.
//   Reset: synchronous, active low; restores the register defaults, zero
//   angle and bias, and the identity covariance.
//   Stall: the result beat is held in an output register until taken; the
//   next sample is accepted meanwhile, and its result waits for the slot.
// ----------------------------------------------------------------------------
module tilt_angle_kalman_filter_top #(
    parameter int WORD_WIDTH = takf_pkg::WORD_WIDTH_DEF,
    parameter int FRAC_BITS  = takf_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    takf_in_if.sink                             i_sample,
    takf_out_if.source                          o_result,
    input  logic                                i_cfg_we,
    input  logic [takf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [takf_pkg::CFG_DAT_W-1:0]      i_cfg_data
);
    import takf_pkg::*;

    localparam int W = WORD_WIDTH;

    // sequencer states, in execution order
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_P_ANG  = 4'd1;
    localparam logic [3:0] S_P_P00  = 4'd2;
    localparam logic [3:0] S_P_P11D = 4'd3;
    localparam logic [3:0] S_P_P11  = 4'd4;
    localparam logic [3:0] S_CHECK  = 4'd5;
    localparam logic [3:0] S_K0     = 4'd6;
    localparam logic [3:0] S_K1     = 4'd7;
    localparam logic [3:0] S_C_P10  = 4'd8;
    localparam logic [3:0] S_C_P11  = 4'd9;
    localparam logic [3:0] S_C_P00  = 4'd10;
    localparam logic [3:0] S_C_P01  = 4'd11;
    localparam logic [3:0] S_C_ANG  = 4'd12;
    localparam logic [3:0] S_C_BIAS = 4'd13;
    localparam logic [3:0] S_OUT    = 4'd14;

    localparam logic signed [W-1:0] ANG_LIM  = W'(ANGLE_LIMIT);
    localparam logic signed [W-1:0] RATE_LIM = W'(RATE_LIMIT);
    localparam logic signed [W-1:0] ONE      = W'(1) << FRAC_BITS;

    // configuration registers
    logic [QA_W-1:0] r_qa;
    logic [QB_W-1:0] r_qb;
    logic [RN_W-1:0] r_rn;
    logic [DT_W-1:0] r_dt;

    // filter state and per-sample working registers
    logic signed [W-1:0] r_angle, n_angle;
    logic signed [W-1:0] r_bias, n_bias;
    logic signed [W-1:0] r_p00, n_p00;
    logic signed [W-1:0] r_p01, n_p01;
    logic signed [W-1:0] r_p10, n_p10;
    logic signed [W-1:0] r_p11, n_p11;
    logic signed [W-1:0] r_meas, n_meas;
    logic signed [W-1:0] r_gyro, n_gyro;
    logic signed [W-1:0] r_err, n_err;
    logic signed [W-1:0] r_e, n_e;
    logic signed [W-1:0] r_k0, n_k0;
    logic signed [W-1:0] r_k1, n_k1;
    logic [3:0]          r_state, n_state;
    logic                r_wait, n_wait;

    // output slot
    logic                       r_ovalid, n_ovalid;
    logic signed [ANGLE_W-1:0]  r_oangle, n_oangle;
    logic signed [RATE_W-1:0]   r_orate, n_orate;

    // arithmetic unit hookup
    t_mdu_ctl            s_ctl;
    t_mdu_sts            s_sts;
    logic signed [W-1:0] s_a, s_b, s_res;
    logic                is_op;

    logic signed [W-1:0] qa_w, qb_w, rn_w, dt_w;
    logic signed [W-1:0] e_new, ang_lim, rate_raw, rate_lim;

    function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                    input logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1]) begin
            sat_add = s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            sat_add = s[W-1:0];
        end
    endfunction

    function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] a,
                                                    input logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = {a[W-1], a} - {b[W-1], b};
        if (s[W] != s[W-1]) begin
            sat_sub = s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            sat_sub = s[W-1:0];
        end
    endfunction

    function automatic logic signed [W-1:0] clip(input logic signed [W-1:0] v,
                                                 input logic signed [W-1:0] lim);
        if (v > lim) begin
            clip = lim;
        end else if (v < -lim) begin
            clip = -lim;
        end else begin
            clip = v;
        end
    endfunction

    assign qa_w = signed'(W'(r_qa));
    assign qb_w = signed'(W'(r_qb));
    assign rn_w = signed'(W'(r_rn));
    assign dt_w = signed'(W'(r_dt));

    // configuration writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qa <= QA_RST;
            r_qb <= QB_RST;
            r_rn <= RN_RST;
            r_dt <= DT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ANGLE_Q: r_qa <= i_cfg_data[QA_W-1:0];
                CFG_BIAS_Q:  r_qb <= i_cfg_data[QB_W-1:0];
                CFG_MEAS_R:  r_rn <= i_cfg_data[RN_W-1:0];
                CFG_PERIOD:  r_dt <= i_cfg_data[DT_W-1:0];
                default: ;
            endcase
        end
    end

    // operand select for the shared unit
    always_comb begin
        is_op = (r_state >= S_P_ANG && r_state <= S_P_P11)
             || (r_state >= S_K0 && r_state <= S_C_BIAS);
        s_ctl.go = is_op && !r_wait;
        s_ctl.op = (r_state == S_K0 || r_state == S_K1) ? OP_DIV : OP_MUL;
        unique case (r_state)
            S_P_ANG:  begin s_a = sat_sub(r_gyro, r_bias);                s_b = dt_w;  end
            S_P_P00:  begin s_a = sat_sub(sat_sub(qa_w, r_p01), r_p10);   s_b = dt_w;  end
            S_P_P11D: begin s_a = r_p11;                                  s_b = dt_w;  end
            S_P_P11:  begin s_a = qb_w;                                   s_b = dt_w;  end
            S_K0:     begin s_a = r_p00;                                  s_b = r_e;   end
            S_K1:     begin s_a = r_p10;                                  s_b = r_e;   end
            S_C_P10:  begin s_a = r_k1;                                   s_b = r_p00; end
            S_C_P11:  begin s_a = r_k1;                                   s_b = r_p01; end
            S_C_P00:  begin s_a = r_k0;                                   s_b = r_p00; end
            S_C_P01:  begin s_a = r_k0;                                   s_b = r_p01; end
            S_C_ANG:  begin s_a = r_k0;                                   s_b = r_err; end
            S_C_BIAS: begin s_a = r_k1;                                   s_b = r_err; end
            default:  begin s_a = '0;                                     s_b = '0;    end
        endcase
    end

    takf_mdu #(
        .W (WORD_WIDTH),
        .F (FRAC_BITS)
    ) u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (s_ctl),
        .i_a     (s_a),
        .i_b     (s_b),
        .o_sts   (s_sts),
        .o_res   (s_res)
    );

    // sequencer: launch an operation, wait for its result, fold it in
    always_comb begin
        n_state  = r_state;
        n_wait   = r_wait;
        n_angle  = r_angle;
        n_bias   = r_bias;
        n_p00    = r_p00;
        n_p01    = r_p01;
        n_p10    = r_p10;
        n_p11    = r_p11;
        n_meas   = r_meas;
        n_gyro   = r_gyro;
        n_err    = r_err;
        n_e      = r_e;
        n_k0     = r_k0;
        n_k1     = r_k1;
        n_ovalid = r_ovalid && !o_result.ready;
        n_oangle = r_oangle;
        n_orate  = r_orate;

        e_new    = sat_add(rn_w, r_p00);
        ang_lim  = clip(r_angle, ANG_LIM);
        rate_raw = sat_sub(r_gyro, r_bias);
        rate_lim = clip(rate_raw, RATE_LIM);

        if (s_ctl.go) begin
            n_wait = 1'b1;
        end

        priority if (r_state == S_IDLE) begin
            if (i_sample.valid) begin
                n_meas  = W'(i_sample.measured_angle);
                n_gyro  = W'(i_sample.gyro_rate);
                n_state = S_P_ANG;
            end
        end else if (r_state == S_CHECK) begin
            n_err   = sat_sub(r_meas, r_angle);
            n_e     = e_new;
            // skip the correction when the innovation variance is not positive
            n_state = (!e_new[W-1] && e_new != '0) ? S_K0 : S_OUT;
        end else if (r_state == S_OUT) begin
            if (!r_ovalid || o_result.ready) begin
                n_ovalid = 1'b1;
                n_oangle = ang_lim[ANGLE_W-1:0];
                n_orate  = rate_lim[RATE_W-1:0];
                n_state  = S_IDLE;
            end
        end else if (is_op && r_wait && s_sts.done) begin
            n_wait  = 1'b0;
            n_state = r_state + 4'd1;
            unique case (r_state)
                S_P_ANG:  n_angle = sat_add(r_angle, s_res);
                S_P_P00:  n_p00   = sat_add(r_p00, s_res);
                S_P_P11D: begin
                    n_p01 = sat_sub(r_p01, s_res);
                    n_p10 = sat_sub(r_p10, s_res);
                end
                S_P_P11:  n_p11   = sat_add(r_p11, s_res);
                S_K0:     n_k0    = s_res;
                S_K1:     n_k1    = s_res;
                S_C_P10:  n_p10   = sat_sub(r_p10, s_res);
                S_C_P11:  n_p11   = sat_sub(r_p11, s_res);
                S_C_P00:  n_p00   = sat_sub(r_p00, s_res);
                S_C_P01:  n_p01   = sat_sub(r_p01, s_res);
                S_C_ANG:  n_angle = sat_add(r_angle, s_res);
                S_C_BIAS: n_bias  = sat_add(r_bias, s_res);
                default: ;
            endcase
        end else begin
            n_state = r_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wait   <= 1'b0;
            r_ovalid <= 1'b0;
            r_angle  <= '0;
            r_bias   <= '0;
            r_p00    <= ONE;
            r_p01    <= '0;
            r_p10    <= '0;
            r_p11    <= ONE;
        end else begin
            r_state  <= n_state;
            r_wait   <= n_wait;
            r_ovalid <= n_ovalid;
            r_angle  <= n_angle;
            r_bias   <= n_bias;
            r_p00    <= n_p00;
            r_p01    <= n_p01;
            r_p10    <= n_p10;
            r_p11    <= n_p11;
        end
        r_meas   <= n_meas;
        r_gyro   <= n_gyro;
        r_err    <= n_err;
        r_e      <= n_e;
        r_k0     <= n_k0;
        r_k1     <= n_k1;
        r_oangle <= n_oangle;
        r_orate  <= n_orate;
    end

    assign i_sample.ready          = (r_state == S_IDLE);
    assign o_result.valid          = r_ovalid;
    assign o_result.filtered_angle = r_oangle;
    assign o_result.corrected_rate = r_orate;

    a_go_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_ctl.go |-> !s_sts.busy)
        else $error("operation launched while the unit is busy");
    a_idle_unit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !s_sts.busy && !r_wait)
        else $error("unit still working while a new beat may enter");
    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_sts.done |=> !s_sts.done)
        else $error("result strobe longer than one cycle");
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == S_OUT && r_state == S_IDLE) |-> r_ovalid)
        else $error("sample finished without loading the result slot");

endmodule

@@ hdl/takf_mdu.sv @@
// ----------------------------------------------------------------------------
// takf_mdu: bit-serial fixed point multiply / divide unit
// Multiply: a*b >> F, rounded half away from zero, one bit per cycle.
// Divide: (a << F) / b for b > 0, restoring, one quotient bit per cycle.
// Both results saturate to the signed word range.
// ----------------------------------------------------------------------------
module takf_mdu #(
    parameter int W = takf_pkg::WORD_WIDTH_DEF,
    parameter int F = takf_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  takf_pkg::t_mdu_ctl  i_ctl,
    input  logic signed [W-1:0] i_a,
    input  logic signed [W-1:0] i_b,
    output takf_pkg::t_mdu_sts  o_sts,
    output logic signed [W-1:0] o_res
);
    import takf_pkg::*;

    localparam int CW = $clog2(W + 2);
    localparam int LW = 2 * W + 1;
    localparam int SH = W + 1 - F;

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_RUN  = 2'd1;
    localparam logic [1:0] P_FIN  = 2'd2;

    logic [1:0]    r_ph, n_ph;
    logic          r_done, n_done;
    logic          r_op, n_op;
    logic          r_neg, n_neg;
    logic          r_ovf, n_ovf;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [W-1:0]  r_x, n_x;
    logic [W-1:0]  r_hi, n_hi;
    logic [W:0]    r_sh, n_sh;
    logic [W-1:0]  r_res, n_res;

    logic [W-1:0]   ma, mb, top;
    logic [W+F-1:0] nfull;
    logic [W:0]     msum, rs, rdif;
    logic           rnd;
    logic [W+1:0]   q;
    logic [LW-1:0]  psum, mag;

    function automatic logic [W-1:0] mag_of(input logic signed [W-1:0] v);
        mag_of = v[W-1] ? W'(-v) : v;
    endfunction

    function automatic logic [W-1:0] sat_mag(input logic neg, input logic [LW-1:0] m);
        logic [LW-1:0] maxu;
        logic [LW-1:0] limn;
        maxu = LW'({(W-1){1'b1}});
        limn = LW'(1) << (W - 1);
        if (!neg) begin
            sat_mag = (m > maxu) ? {1'b0, {(W-1){1'b1}}} : m[W-1:0];
        end else begin
            sat_mag = (m > limn) ? {1'b1, {(W-1){1'b0}}} : W'(-m[W-1:0]);
        end
    endfunction

    always_comb begin
        ma    = mag_of(i_a);
        mb    = mag_of(i_b);
        top   = ma >> SH;
        nfull = {ma, {F{1'b0}}};
        msum  = {1'b0, r_hi} + (r_sh[0] ? {1'b0, r_x} : '0);
        rs    = {r_hi, r_sh[W]};
        rdif  = rs - {1'b0, r_x};
        rnd   = {r_hi, 1'b0} >= {1'b0, r_x};
        q     = {1'b0, r_sh} + (W+2)'(rnd);
        psum  = {1'b0, r_hi, r_sh[W-1:0]} + (LW'(1) << (F - 1));
        if (r_op == OP_MUL) begin
            mag = psum >> F;
        end else begin
            mag = r_ovf ? '1 : LW'(q);
        end

        n_ph   = r_ph;
        n_done = 1'b0;
        n_op   = r_op;
        n_neg  = r_neg;
        n_ovf  = r_ovf;
        n_cnt  = r_cnt;
        n_x    = r_x;
        n_hi   = r_hi;
        n_sh   = r_sh;
        n_res  = r_res;
        unique case (r_ph)
            P_IDLE: begin
                if (i_ctl.go) begin
                    n_op = i_ctl.op;
                    n_ph = P_RUN;
                    if (i_ctl.op == OP_MUL) begin
                        n_x   = ma;
                        n_hi  = '0;
                        n_sh  = {1'b0, mb};
                        n_neg = i_a[W-1] ^ i_b[W-1];
                        n_ovf = 1'b0;
                        n_cnt = CW'(W);
                    end else begin
                        n_x   = mb;
                        n_hi  = top;
                        n_sh  = nfull[W:0];
                        n_neg = i_a[W-1];
                        n_ovf = top >= mb;
                        n_cnt = CW'(W + 1);
                    end
                end
            end
            P_RUN: begin
                // one bit per cycle: shift-add or shift-subtract
                if (r_op == OP_MUL) begin
                    n_hi = msum[W:1];
                    n_sh = {1'b0, msum[0], r_sh[W-1:1]};
                end else begin
                    if (!rdif[W]) begin
                        n_hi = rdif[W-1:0];
                        n_sh = {r_sh[W-1:0], 1'b1};
                    end else begin
                        n_hi = rs[W-1:0];
                        n_sh = {r_sh[W-1:0], 1'b0};
                    end
                end
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_ph = P_FIN;
                end
            end
            P_FIN: begin
                n_res  = sat_mag(r_neg, mag);
                n_done = 1'b1;
                n_ph   = P_IDLE;
            end
            default: begin
                n_ph = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= P_IDLE;
            r_done <= 1'b0;
        end else begin
            r_ph   <= n_ph;
            r_done <= n_done;
        end
        r_op  <= n_op;
        r_neg <= n_neg;
        r_ovf <= n_ovf;
        r_cnt <= n_cnt;
        r_x   <= n_x;
        r_hi  <= n_hi;
        r_sh  <= n_sh;
        r_res <= n_res;
    end

    assign o_sts.busy = (r_ph != P_IDLE);
    assign o_sts.done = r_done;
    assign o_res      = signed'(r_res);

    a_done_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_ph) == P_FIN)
        else $error("result strobe without a finishing cycle");
    a_go_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ph == P_RUN && r_cnt == CW'(0)) |-> 1'b0)
        else $error("run phase with an exhausted bit counter");
    a_fin_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ph == P_FIN |=> r_ph == P_IDLE && r_done)
        else $error("finishing cycle did not return to idle");

endmodule

@@ dv/tilt_angle_kalman_filter_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tilt_angle_kalman_filter_top_tb: self-checking bench of the tilt filter
// Streams IMU samples through the filter under several noise/period settings
// and idle/stall mixes, predicts every result with a fixed point model of the
// filter and compares each result beat field by field in order.
// ----------------------------------------------------------------------------
module tilt_angle_kalman_filter_top_tb;
    import takf_pkg::*;

    localparam int      FRAC        = FRAC_BITS_DEF;
    localparam longint  WORD_HI     = (64'sd1 <<< (WORD_WIDTH_DEF - 1)) - 1;
    localparam longint  WORD_LO     = -WORD_HI - 1;
    localparam longint  ONE         = 64'sd1 <<< FRAC;
    localparam int      LATENCY     = 12 * WORD_WIDTH_DEF + 40;
    localparam int      STUCK_LIMIT = 20000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd5;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        logic signed [ANGLE_W-1:0] angle;
        logic signed [RATE_W-1:0]  rate;
    } t_imu_sample;

    typedef struct {
        logic signed [ANGLE_W-1:0] angle;
        logic signed [RATE_W-1:0]  rate;
    } t_fused;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    takf_in_if  smp_if ();
    takf_out_if res_if ();

    tilt_angle_kalman_filter_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (smp_if),
        .o_result   (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // ------------------------------------------------------------------------
    // Filter model: its own copy of the registers and the state
    // ------------------------------------------------------------------------
    longint q_angle, q_bias, r_meas, dt;
    longint est_angle, est_bias, p_aa, p_ab, p_ba, p_bb;

    function automatic longint sat_word(t_wide v);
        if (v > t_wide'(WORD_HI)) return WORD_HI;
        if (v < t_wide'(WORD_LO)) return WORD_LO;
        return longint'(v);
    endfunction

    function automatic longint add_sat(longint a, longint b);
        return sat_word(t_wide'(a) + t_wide'(b));
    endfunction

    function automatic longint sub_sat(longint a, longint b);
        return sat_word(t_wide'(a) - t_wide'(b));
    endfunction

    // product rescaled by FRAC, ties away from zero
    function automatic longint fx_mul(longint a, longint b);
        t_wide p;
        logic [127:0] m;
        p = t_wide'(a) * t_wide'(b);
        m = (p < 0) ? -p : p;
        m = (m + (128'd1 << (FRAC - 1))) >> FRAC;
        return sat_word((p < 0) ? -t_wide'(m) : t_wide'(m));
    endfunction

    // n * 2^FRAC / d for d > 0, ties away from zero
    function automatic longint fx_div(longint n, longint d);
        logic [127:0] m, q, r, dd;
        dd = 128'(d);
        m = (n < 0) ? 128'(-t_wide'(n)) : 128'(n);
        m = m << FRAC;
        q = m / dd;
        r = m - q * dd;
        if (r >= dd - r) q = q + 1;
        return sat_word((n < 0) ? -t_wide'(q) : t_wide'(q));
    endfunction

    function automatic longint clip(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    task automatic model_reset();
        q_angle = longint'(QA_RST);
        q_bias  = longint'(QB_RST);
        r_meas  = longint'(RN_RST);
        dt      = longint'(DT_RST);
        est_angle = 0;
        est_bias  = 0;
        p_aa = ONE;
        p_ab = 0;
        p_ba = 0;
        p_bb = ONE;
    endtask

    // predict, correct, and return the fused beat for one sample
    function automatic t_fused fuse_sample(t_imu_sample s);
        longint meas, gyro, drift, p11dt, innov, var_e, k0, k1, t0, t1;
        t_fused f;
        meas = longint'(s.angle);
        gyro = longint'(s.rate);
        est_angle = add_sat(est_angle, fx_mul(sub_sat(gyro, est_bias), dt));
        drift = sub_sat(sub_sat(q_angle, p_ab), p_ba);
        p11dt = fx_mul(p_bb, dt);
        p_aa  = add_sat(p_aa, fx_mul(drift, dt));
        p_ab  = sub_sat(p_ab, p11dt);
        p_ba  = sub_sat(p_ba, p11dt);
        p_bb  = add_sat(p_bb, fx_mul(q_bias, dt));
        innov = sub_sat(meas, est_angle);
        var_e = add_sat(r_meas, p_aa);
        // skip the correction when the innovation variance is not positive
        if (var_e > 0) begin
            k0 = fx_div(p_aa, var_e);
            k1 = fx_div(p_ba, var_e);
            t0 = p_aa;
            t1 = p_ab;
            p_aa = sub_sat(p_aa, fx_mul(k0, t0));
            p_ab = sub_sat(p_ab, fx_mul(k0, t1));
            p_ba = sub_sat(p_ba, fx_mul(k1, t0));
            p_bb = sub_sat(p_bb, fx_mul(k1, t1));
            est_angle = add_sat(est_angle, fx_mul(k0, innov));
            est_bias  = add_sat(est_bias, fx_mul(k1, innov));
        end
        f.angle = ANGLE_W'(clip(est_angle, ANGLE_LIMIT));
        f.rate  = RATE_W'(clip(sub_sat(gyro, est_bias), RATE_LIMIT));
        return f;
    endfunction

    // ------------------------------------------------------------------------
    // Queues, counters and idle knobs
    // ------------------------------------------------------------------------
    t_imu_sample pending_samples[$];
    t_fused      fused_due[$];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          mismatches = 0;
    int          beats_checked = 0;
    int          samples_sent = 0;
    int          cfg_writes = 0;
    int          stuck_cycles = 0;
    bit          smp_taken = 1'b0;

    // ------------------------------------------------------------------------
    // Accept side: predict on each sample beat, watch for a hung pipeline
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        smp_taken = i_rst_n && smp_if.valid && smp_if.ready;
        if (smp_taken) begin
            fused_due.push_back(fuse_sample(pending_samples[0]));
            pending_samples.pop_front();
            samples_sent++;
        end
        if (smp_taken || (res_if.valid && res_if.ready) ||
            (pending_samples.size() == 0 && fused_due.size() == 0)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", STUCK_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driver: hold a presented beat until taken, otherwise maybe idle
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!smp_if.valid || smp_taken) begin
            if (pending_samples.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                smp_if.valid          <= 1'b1;
                smp_if.measured_angle <= pending_samples[0].angle;
                smp_if.gyro_rate      <= pending_samples[0].rate;
            end else begin
                smp_if.valid <= 1'b0;
            end
        end
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each result beat with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_fused want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (fused_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: angle %0d rate %0d",
                             res_if.filtered_angle, res_if.corrected_rate);
            end else begin
                want = fused_due.pop_front();
                beats_checked++;
                if (res_if.filtered_angle !== want.angle ||
                    res_if.corrected_rate !== want.rate) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("beat %0d: angle exp %0d got %0d, rate exp %0d got %0d",
                                 beats_checked, want.angle, res_if.filtered_angle,
                                 want.rate, res_if.corrected_rate);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic longint span(longint lim);
        logic [63:0] u;
        u = {$urandom, $urandom};
        return longint'(u % 64'(2 * lim + 1)) - lim;
    endfunction

    task automatic queue_sample(longint a, longint r);
        t_imu_sample s;
        s.angle = a[ANGLE_W-1:0];
        s.rate  = r[RATE_W-1:0];
        pending_samples.push_back(s);
    endtask

    // write one register between edges; the model follows at once
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_ANGLE_Q: q_angle = longint'(val[QA_W-1:0]);
            CFG_BIAS_Q:  q_bias  = longint'(val[QB_W-1:0]);
            CFG_MEAS_R:  r_meas  = longint'(val[RN_W-1:0]);
            CFG_PERIOD:  dt      = longint'(val[DT_W-1:0]);
            default: begin
            end
        endcase
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_regs(longint qa, longint qb, longint rn, longint per);
        write_reg(CFG_ANGLE_Q, qa[CFG_DAT_W-1:0]);
        write_reg(CFG_BIAS_Q,  qb[CFG_DAT_W-1:0]);
        write_reg(CFG_MEAS_R,  rn[CFG_DAT_W-1:0]);
        write_reg(CFG_PERIOD,  per[CFG_DAT_W-1:0]);
    endtask

    // drain: let every queued sample and its result go through
    task automatic drain();
        while (pending_samples.size() != 0 || fused_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // mostly a smooth tilt track with noise; some full range and raw bits
    task automatic queue_random(int n);
        longint track, spin;
        int     pick;
        track = span(64'sd1509949440);
        spin  = span(64'sd1677721600);
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                track = clip(track + span(64'sd83886080), 64'sd1509949440);
                if ($urandom_range(9) == 0) spin = span(64'sd8388608000);
                queue_sample(track + span(64'sd16777216), spin + span(64'sd33554432));
            end else if (pick < 90) begin
                queue_sample(span(ANGLE_LIMIT), span(RATE_LIMIT));
            end else begin
                queue_sample(longint'({$urandom, $urandom}), longint'({$urandom, $urandom}));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_ANGLE_Q;
        i_cfg_data = '0;
        smp_if.valid          = 1'b0;
        smp_if.measured_angle = '0;
        smp_if.gyro_rate      = '0;
        res_if.ready          = 1'b0;
        model_reset();
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: field extremes at reset defaults
        queue_sample(0, 0);
        queue_sample(ANGLE_LIMIT, RATE_LIMIT);
        queue_sample(-ANGLE_LIMIT, -RATE_LIMIT);
        queue_sample(ANGLE_LIMIT, -RATE_LIMIT);
        queue_sample(-ANGLE_LIMIT, RATE_LIMIT);
        // beyond the field ranges, up to the raw bit limits
        queue_sample((64'sd1 <<< 32) - 1, (64'sd1 <<< 35) - 1);
        queue_sample(-(64'sd1 <<< 32), -(64'sd1 <<< 35));
        queue_sample(-1, -1);
        queue_sample(1, 1);
        drain();

        // directed: zero noise terms and the shortest period drive the
        // innovation variance to zero, which skips the correction
        set_regs(0, 0, 0, 1);
        write_reg(CFG_UNUSED, '1);
        for (int k = 0; k < 6; k++) queue_sample(0, 0);
        queue_sample(ANGLE_LIMIT, RATE_LIMIT);
        queue_sample(-ANGLE_LIMIT, -RATE_LIMIT);
        drain();

        // directed: each register with only its top bit set
        set_regs(64'sd1 <<< 24, 64'sd1 <<< 24, 64'sd1 <<< 28, 64'sd1 <<< 24);
        queue_sample(ANGLE_LIMIT, RATE_LIMIT);
        queue_sample(-ANGLE_LIMIT, -RATE_LIMIT);
        queue_sample(ANGLE_LIMIT, 0);
        queue_sample(0, -RATE_LIMIT);
        drain();
        // all-ones writes are masked to each register's width
        set_regs(-1, -1, -1, -1);
        queue_sample(-ANGLE_LIMIT, RATE_LIMIT);
        queue_sample(ANGLE_LIMIT, -RATE_LIMIT);
        drain();

        // random phases: each idle mix with a different setting
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_regs(longint'(QA_RST), longint'(QB_RST), longint'(RN_RST),
                            longint'(DT_RST));
                1: set_regs($urandom_range(1 << 24), $urandom_range(1 << 24),
                            $urandom_range(1, 1 << 28), $urandom_range(1, 1 << 24));
                2: set_regs(0, 0, 1, 1);
                default: set_regs($urandom_range(1 << 20), $urandom_range(1 << 20),
                                  $urandom_range(1, 1 << 26), $urandom_range(1, 1 << 20));
            endcase
            send_idle_pct  = (ph == 1) ? 70 : (ph == 3) ? 7 : 0;
            recv_stall_pct = (ph == 2) ? 70 : (ph == 3) ? 7 : 0;
            queue_random(145);
            drain();
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end

        repeat (LATENCY + 16) @(posedge i_clk);
        $display("covered %0d samples and %0d result beats across %0d register writes,",
                 samples_sent, beats_checked, cfg_writes);
        $display("four idle/stall mixes, field extremes and skipped corrections");
        if (mismatches == 0 && fused_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, fused_due.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ tilt_angle_kalman_filter_top.f @@
hdl/takf_pkg.sv
hdl/takf_in_if.sv
hdl/takf_out_if.sv
hdl/takf_mdu.sv
hdl/tilt_angle_kalman_filter_top.sv
dv/tilt_angle_kalman_filter_top_tb.sv
